// ===== sv/assert_macros.svh =====
// Assertion macros shared by the checker files.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication that starts in the same cycle.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check an implication whose consequent is due in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ffbp_pkg.sv =====
// Package for the first-fit bin packer: widths, status codes, control structs.
// No dependencies.
package ffbp_pkg;

  localparam int DATA_W       = 16;   // item size, fill and capacity
  localparam int LAST_W       = 1;
  localparam int OUT_IDX_W    = 7;    // bin_index field
  localparam int OUT_USED_W   = 8;    // bins_used field
  localparam int STATUS_W     = 2;
  localparam int NUM_BINS_DEF = 128;
  localparam logic [DATA_W-1:0] CAP_RESET = DATA_W'(100);

  typedef enum logic [STATUS_W-1:0] {
    ST_PLACED   = 2'd0,
    ST_OVERSIZE = 2'd1,
    ST_NO_BIN   = 2'd2
  } ffbp_status_t;

  // controller -> datapath
  typedef struct packed {
    logic start;   // latch a new word, restart the walk
    logic scan;    // walk the open bins
    logic finish;  // capture the outcome of the walk
    logic commit;  // update table, load the output register
  } ffbp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic oversize;
    logic hit;
    logic miss;
    logic out_free;
  } ffbp_sts_t;

endpackage

// ===== sv/ffbp_in_if.sv =====
// Input channel of the bin packer: valid/ready plus one item word.
// Depends on ffbp_pkg.
interface ffbp_in_if;
  logic                          valid;
  logic                          ready;
  logic [ffbp_pkg::DATA_W-1:0]   item_size;
  logic [ffbp_pkg::LAST_W-1:0]   last_item;

  modport source (output valid, item_size, last_item, input ready);
  modport sink   (input valid, item_size, last_item, output ready);
endinterface

// ===== sv/ffbp_out_if.sv =====
// Result channel of the bin packer: valid/ready plus one result word.
// Depends on ffbp_pkg.
interface ffbp_out_if;
  logic                            valid;
  logic                            ready;
  logic [ffbp_pkg::OUT_IDX_W-1:0]  bin_index;
  logic [ffbp_pkg::DATA_W-1:0]     bin_fill;
  logic [ffbp_pkg::OUT_USED_W-1:0] bins_used;
  logic [ffbp_pkg::STATUS_W-1:0]   status;

  modport source (output valid, bin_index, bin_fill, bins_used, status, input ready);
  modport sink   (input valid, bin_index, bin_fill, bins_used, status, output ready);
endinterface

// ===== sv/first_fit_bin_packer_core.sv =====
// First-fit bin packer, top level. Depends on ffbp_pkg, ffbp_in_if, ffbp_out_if,
// ffbp_ctrl and ffbp_dpath.
// The walk checks the open bins in order, one fill read a cycle, and stops at the first
// bin that takes the word; an oversize word ends the walk without a bin. A new word is
// accepted only after the previous one has been committed to the table and the output register.
// Reset (rst_n low, synchronous): table empty, capacity 100, both channels idle.
module first_fit_bin_packer_core #(
  parameter int NUM_BINS = ffbp_pkg::NUM_BINS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [ffbp_pkg::DATA_W-1:0] cfg_wdata,
  ffbp_in_if.sink                     in_ch,
  ffbp_out_if.source                  out_ch
);

  // Controller and datapath talk only through these two bundles.
  ffbp_pkg::ffbp_cmd_t cmd;
  ffbp_pkg::ffbp_sts_t sts;

  // Controller: ready only while idle; one word is in flight at a time.
  // It walks, captures the outcome, then waits for the output register
  // to drain before it updates the table, so a finished result can sit
  // on the output while the next word is already accepted and walked.
  ffbp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: fill memory with a registered read, a one-stage fit check
  // (fill + size against capacity), the open-bin count and the output register.
  // Clearing the table at the end of a set only resets the open-bin count:
  // entries at or above the count are never read, and a new bin starts from zero.
  ffbp_dpath #(
    .NUM_BINS (NUM_BINS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_item_size  (in_ch.item_size),
    .in_last_item  (in_ch.last_item),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_bin_index (out_ch.bin_index),
    .out_bin_fill  (out_ch.bin_fill),
    .out_bins_used (out_ch.bins_used),
    .out_status    (out_ch.status)
  );

endmodule

// ===== sv/ffbp_ctrl.sv =====
// Control state machine of the bin packer: accept, walk, commit.
// Depends on ffbp_pkg.
module ffbp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ffbp_pkg::ffbp_sts_t sts,
  output ffbp_pkg::ffbp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.oversize || sts.hit || sts.miss) begin
          cmd.finish = 1'b1;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register frees up
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/ffbp_dpath.sv =====
// Datapath of the bin packer: fill memory, walk pointer, fit check, output register.
// Depends on ffbp_pkg.
module ffbp_dpath #(
  parameter int NUM_BINS = ffbp_pkg::NUM_BINS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ffbp_pkg::ffbp_cmd_t               cmd,
  output ffbp_pkg::ffbp_sts_t               sts,
  input  logic                              cfg_we,
  input  logic [ffbp_pkg::DATA_W-1:0]       cfg_wdata,
  input  logic [ffbp_pkg::DATA_W-1:0]       in_item_size,
  input  logic [ffbp_pkg::LAST_W-1:0]       in_last_item,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [ffbp_pkg::OUT_IDX_W-1:0]    out_bin_index,
  output logic [ffbp_pkg::DATA_W-1:0]       out_bin_fill,
  output logic [ffbp_pkg::OUT_USED_W-1:0]   out_bins_used,
  output logic [ffbp_pkg::STATUS_W-1:0]     out_status
);

  localparam int DW    = ffbp_pkg::DATA_W;
  localparam int IDX_W = $clog2(NUM_BINS);
  localparam int CNT_W = $clog2(NUM_BINS + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(NUM_BINS);

  // configuration
  logic [DW-1:0]    cap_r;

  // item being placed
  logic [DW-1:0]    size_r;
  logic             last_r;

  // table state: entries at or above open_bins_r are never read
  logic [DW-1:0]    mem_r [NUM_BINS];
  logic [CNT_W-1:0] open_bins_r;

  // walk
  logic [CNT_W-1:0] scan_cnt_r;
  logic [IDX_W-1:0] chk_addr_r;
  logic             chk_vld_r;
  logic [DW-1:0]    rd_data_r;

  // captured outcome
  logic [IDX_W-1:0]             res_idx_r;
  logic [DW-1:0]                res_fill_r;
  logic [CNT_W-1:0]             res_used_r;
  ffbp_pkg::ffbp_status_t       res_status_r;
  logic                         res_wr_r;

  // output register
  logic                         out_valid_r;
  logic [IDX_W-1:0]             out_idx_r;
  logic [DW-1:0]                out_fill_r;
  logic [CNT_W-1:0]             out_used_r;
  ffbp_pkg::ffbp_status_t       out_status_r;

  logic [DW:0]      sum;
  logic             fits;
  logic             issue;

  assign sum   = {1'b0, rd_data_r} + {1'b0, size_r};
  assign fits  = sum <= {1'b0, cap_r};
  assign issue = cmd.scan && (scan_cnt_r < open_bins_r);

  assign sts.oversize = size_r > cap_r;
  assign sts.hit      = chk_vld_r && fits;
  assign sts.miss     = !chk_vld_r && (scan_cnt_r >= open_bins_r);
  assign sts.out_free = !out_valid_r || out_ready;

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= ffbp_pkg::CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      size_r <= in_item_size;
      last_r <= in_last_item[0];
    end
  end

  // walk pointer and check stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_vld_r  <= 1'b0;
      scan_cnt_r <= '0;
    end else begin
      chk_vld_r <= issue;
      if (cmd.start) begin
        scan_cnt_r <= '0;
      end else if (issue) begin
        scan_cnt_r <= scan_cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_addr_r <= scan_cnt_r[IDX_W-1:0];
  end

  // fill memory: one read and one write port
  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[scan_cnt_r[IDX_W-1:0]];
    if (cmd.commit && res_wr_r) begin
      mem_r[res_idx_r] <= res_fill_r;
    end
  end

  // capture the outcome of the walk
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_idx_r    <= '0;
      res_fill_r   <= '0;
      res_used_r   <= open_bins_r;
      res_wr_r     <= 1'b0;
      res_status_r <= ffbp_pkg::ST_PLACED;
      if (sts.oversize) begin
        res_status_r <= ffbp_pkg::ST_OVERSIZE;
      end else if (sts.hit) begin
        res_idx_r  <= chk_addr_r;
        res_fill_r <= sum[DW-1:0];
        res_wr_r   <= 1'b1;
      end else if (open_bins_r < FULL) begin
        // open the next bin; its fill starts from zero
        res_idx_r  <= open_bins_r[IDX_W-1:0];
        res_fill_r <= size_r;
        res_used_r <= open_bins_r + CNT_W'(1);
        res_wr_r   <= 1'b1;
      end else begin
        res_status_r <= ffbp_pkg::ST_NO_BIN;
      end
    end
  end

  // bin count and output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_bins_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        open_bins_r <= last_r ? '0 : res_used_r;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_idx_r    <= res_idx_r;
      out_fill_r   <= res_fill_r;
      out_used_r   <= res_used_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_bin_index = ffbp_pkg::OUT_IDX_W'(out_idx_r);
  assign out_bin_fill  = out_fill_r;
  assign out_bins_used = ffbp_pkg::OUT_USED_W'(out_used_r);
  assign out_status    = out_status_r;

endmodule

// ===== sv/ffbp_checker.sv =====
// Port-level checker for first_fit_bin_packer_core, attached by bind.
// Depends on ffbp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ffbp_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [ffbp_pkg::OUT_IDX_W-1:0]  out_bin_index,
  input logic [ffbp_pkg::DATA_W-1:0]     out_bin_fill,
  input logic [ffbp_pkg::OUT_USED_W-1:0] out_bins_used,
  input logic [ffbp_pkg::STATUS_W-1:0]   out_status
);

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result word dropped while stalled")
  `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_bin_index) && $stable(out_bin_fill) && $stable(out_bins_used) && $stable(out_status), "result word changed while stalled")
  `ASSERT_NEXT(a_in_one, clk, rst_n, in_valid && in_ready, !in_ready, "second word taken while one is in flight")
  `ASSERT_SAME(a_reject_zero, clk, rst_n, out_valid && (out_status != ffbp_pkg::ST_PLACED), (out_bin_index == '0) && (out_bin_fill == '0), "rejected word carries a bin or fill")

endmodule

bind first_fit_bin_packer_core ffbp_checker u_ffbp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_bin_index (out_ch.bin_index),
  .out_bin_fill  (out_ch.bin_fill),
  .out_bins_used (out_ch.bins_used),
  .out_status    (out_ch.status)
);
